/* sv/csp_fsm_pkg.sv */
// Shared types and codes for the call setup protocol state machine.
// No dependencies; used by call_setup_protocol_fsm_top.
package csp_fsm_pkg;

    // Call states, numbered as they appear on the result port.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_IAM_SENT = 4'd1,
        ST_IAM_RCVD = 4'd2,
        ST_EOS_SENT = 4'd3,
        ST_EOS_RCVD = 4'd4,
        ST_ALT_SENT = 4'd5,
        ST_ALT_RCVD = 4'd6,
        ST_ANM_SENT = 4'd7,
        ST_ANM_RCVD = 4'd8,
        ST_SUS_SENT = 4'd9,
        ST_SUS_RCVD = 4'd10
    } t_call_state;

    // Verdict codes returned with each result.
    typedef enum logic [2:0] {
        V_ANALYZE = 3'd0,
        V_TIMEOUT = 3'd1,
        V_INVALID = 3'd2,
        V_DISCARD = 3'd3,
        V_SEND    = 3'd4,
        V_PURGE   = 3'd5
    } t_verdict;

    // Signal kinds carried in the mode field.
    typedef enum logic [2:0] {
        M_TIMEOUT  = 3'd0,
        M_INITIAL  = 3'd1,
        M_PROGRESS = 3'd2,
        M_ANSWER   = 3'd3,
        M_RELEASE  = 3'd4
    } t_sig_mode;

    // Progress report kinds.
    typedef enum logic [2:0] {
        K_EOS     = 3'd0,
        K_ALERT   = 3'd1,
        K_SUSPEND = 3'd2,
        K_RESUME  = 3'd3,
        K_MEDIA   = 3'd4,
        K_OTHER   = 3'd5
    } t_prog_kind;

    // Configuration register indexes.
    localparam logic CFG_IAM_TIMER_ENABLE     = 1'b0;
    localparam logic CFG_PURGE_EARLY_PROGRESS = 1'b1;

    // Direction codes.
    localparam logic DIR_RECEIVED = 1'b0;
    localparam logic DIR_SENT     = 1'b1;

endpackage

/* sv/call_setup_protocol_fsm_top.sv */
// Call setup protocol state machine: top level with input and result registers.
// Depends on csp_fsm_pkg for state, verdict, mode and kind codes.

// Each request names one call-control signal, received or being sent. The
// block checks it against the stored call state, moves the state, keeps the
// response-timer flag and returns one result: a verdict, the call state after
// the signal and start/stop requests for the timer. A request is held in an
// input register until the result register can take its result; then the
// result is loaded into the output register and the call state is updated
// together. One request is taken every cycle while the result port is not
// stalled; the figure is set by the single evaluation stage between the
// input register and the result register, which advances whenever the
// result register is empty or being drained. Configuration writes take
// effect at the clock edge of the write and are meant to be made while no
// request is in flight.
module call_setup_protocol_fsm_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_direction,
    input  logic [2:0] i_mode,
    input  logic [2:0] i_progress_kind,
    input  logic       i_timeout_is_ours,
    input  logic       i_more_queued,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_verdict,
    output logic [3:0] o_call_state_out,
    output logic       o_start_timer,
    output logic       o_stop_timer
);

    // Configuration registers.
    logic r_iam_timer_enable;
    logic r_purge_early_progress;

    // Input register.
    logic       r_in_valid;
    logic       r_direction;
    logic [2:0] r_mode;
    logic [2:0] r_progress_kind;
    logic       r_timeout_is_ours;
    logic       r_more_queued;

    // Call state.
    csp_fsm_pkg::t_call_state r_call_state, n_call_state;
    logic                     r_timer_running, n_timer_running;

    // Result register.
    logic                  r_out_valid;
    csp_fsm_pkg::t_verdict r_verdict;
    logic [3:0]            r_call_state_out;
    logic                  r_start_timer;
    logic                  r_stop_timer;

    // Decode results.
    logic                  c_ok;
    logic                  c_timeout;
    logic                  c_discard;
    logic                  c_early;
    logic                  c_media_sent;
    logic                  c_start;
    logic                  c_stop;
    csp_fsm_pkg::t_verdict c_verdict;

    logic w_advance;
    logic w_in_accept;

    // The evaluation stage moves when it holds a request and the result
    // register is free or being emptied this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iam_timer_enable     <= 1'b0;
            r_purge_early_progress <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csp_fsm_pkg::CFG_IAM_TIMER_ENABLE:     r_iam_timer_enable     <= i_cfg_data;
                csp_fsm_pkg::CFG_PURGE_EARLY_PROGRESS: r_purge_early_progress <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_direction       <= i_direction;
            r_mode            <= i_mode;
            r_progress_kind   <= i_progress_kind;
            r_timeout_is_ours <= i_timeout_is_ours;
            r_more_queued     <= i_more_queued;
        end
    end

    // Next-state logic: decides whether the signal is accepted in the current
    // state and where the call goes. A rejected signal leaves the state as is.
    always_comb begin
        n_call_state    = r_call_state;
        n_timer_running = r_timer_running;
        c_ok            = 1'b0;
        c_timeout       = 1'b0;
        c_discard       = 1'b0;
        c_early         = 1'b0;
        c_media_sent    = 1'b0;
        c_start         = 1'b0;
        if (r_direction == csp_fsm_pkg::DIR_RECEIVED) begin
            case (csp_fsm_pkg::t_sig_mode'(r_mode))
                csp_fsm_pkg::M_TIMEOUT: begin
                    if (r_timeout_is_ours) begin
                        c_timeout = 1'b1;
                    end else begin
                        c_ok = 1'b1;
                    end
                end
                csp_fsm_pkg::M_INITIAL: begin
                    if (r_call_state == csp_fsm_pkg::ST_IDLE) begin
                        n_call_state = csp_fsm_pkg::ST_IAM_RCVD;
                        c_ok         = 1'b1;
                    end
                end
                csp_fsm_pkg::M_PROGRESS: begin
                    case (csp_fsm_pkg::t_prog_kind'(r_progress_kind))
                        csp_fsm_pkg::K_EOS: begin
                            if (r_call_state == csp_fsm_pkg::ST_IAM_SENT) begin
                                n_call_state = csp_fsm_pkg::ST_EOS_RCVD;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_ALERT: begin
                            if (r_call_state inside {csp_fsm_pkg::ST_IAM_SENT,
                                                     csp_fsm_pkg::ST_EOS_RCVD}) begin
                                n_call_state = csp_fsm_pkg::ST_ALT_RCVD;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_SUSPEND: begin
                            if (r_call_state == csp_fsm_pkg::ST_ANM_RCVD) begin
                                n_call_state = csp_fsm_pkg::ST_SUS_RCVD;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_RESUME: begin
                            if (r_call_state == csp_fsm_pkg::ST_SUS_RCVD) begin
                                n_call_state = csp_fsm_pkg::ST_ANM_RCVD;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_MEDIA: begin
                            if (r_call_state != csp_fsm_pkg::ST_IDLE) begin
                                c_discard = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                csp_fsm_pkg::M_ANSWER: begin
                    if (r_call_state inside {csp_fsm_pkg::ST_IAM_SENT,
                                             csp_fsm_pkg::ST_EOS_RCVD,
                                             csp_fsm_pkg::ST_ALT_RCVD}) begin
                        n_call_state = csp_fsm_pkg::ST_ANM_RCVD;
                        c_ok         = 1'b1;
                    end
                end
                csp_fsm_pkg::M_RELEASE: begin
                    if (r_call_state != csp_fsm_pkg::ST_IDLE) begin
                        n_call_state = csp_fsm_pkg::ST_IDLE;
                        c_ok         = 1'b1;
                    end
                end
                default: ;
            endcase
            // Any received signal but a discarded media update ends the timer.
            if (!c_discard) begin
                n_timer_running = 1'b0;
            end
        end else begin
            case (csp_fsm_pkg::t_sig_mode'(r_mode))
                csp_fsm_pkg::M_INITIAL: begin
                    if (r_call_state == csp_fsm_pkg::ST_IDLE) begin
                        n_call_state = csp_fsm_pkg::ST_IAM_SENT;
                        c_ok         = 1'b1;
                        if (r_iam_timer_enable) begin
                            c_start         = 1'b1;
                            n_timer_running = 1'b1;
                        end
                    end
                end
                csp_fsm_pkg::M_PROGRESS: begin
                    case (csp_fsm_pkg::t_prog_kind'(r_progress_kind))
                        csp_fsm_pkg::K_EOS: begin
                            if (r_call_state == csp_fsm_pkg::ST_IAM_RCVD) begin
                                n_call_state = csp_fsm_pkg::ST_EOS_SENT;
                                c_ok         = 1'b1;
                                c_early      = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_ALERT: begin
                            if (r_call_state inside {csp_fsm_pkg::ST_IAM_RCVD,
                                                     csp_fsm_pkg::ST_EOS_SENT}) begin
                                n_call_state = csp_fsm_pkg::ST_ALT_SENT;
                                c_ok         = 1'b1;
                                c_early      = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_SUSPEND: begin
                            if (r_call_state == csp_fsm_pkg::ST_ANM_SENT) begin
                                n_call_state = csp_fsm_pkg::ST_SUS_SENT;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_RESUME: begin
                            if (r_call_state == csp_fsm_pkg::ST_SUS_SENT) begin
                                n_call_state = csp_fsm_pkg::ST_ANM_SENT;
                                c_ok         = 1'b1;
                            end
                        end
                        csp_fsm_pkg::K_MEDIA: begin
                            if (r_call_state != csp_fsm_pkg::ST_IDLE) begin
                                c_ok         = 1'b1;
                                c_media_sent = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                csp_fsm_pkg::M_ANSWER: begin
                    if (r_call_state inside {csp_fsm_pkg::ST_IAM_RCVD,
                                             csp_fsm_pkg::ST_EOS_SENT,
                                             csp_fsm_pkg::ST_ALT_SENT}) begin
                        n_call_state = csp_fsm_pkg::ST_ANM_SENT;
                        c_ok         = 1'b1;
                    end
                end
                csp_fsm_pkg::M_RELEASE: begin
                    if (r_call_state != csp_fsm_pkg::ST_IDLE) begin
                        n_call_state = csp_fsm_pkg::ST_IDLE;
                        c_ok         = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output logic: verdict and the timer stop request.
    always_comb begin
        c_stop = 1'b0;
        if (r_direction == csp_fsm_pkg::DIR_RECEIVED) begin
            c_stop = r_timer_running && !c_timeout && !c_discard;
            if (c_timeout) begin
                c_verdict = csp_fsm_pkg::V_TIMEOUT;
            end else if (c_discard) begin
                c_verdict = csp_fsm_pkg::V_DISCARD;
            end else if (c_ok) begin
                c_verdict = csp_fsm_pkg::V_ANALYZE;
            end else begin
                c_verdict = csp_fsm_pkg::V_INVALID;
            end
        end else begin
            if (c_ok && !(c_early && r_purge_early_progress)
                     && !(c_media_sent && r_more_queued)) begin
                c_verdict = csp_fsm_pkg::V_SEND;
            end else begin
                c_verdict = csp_fsm_pkg::V_PURGE;
            end
        end
    end

    // State and result registers move together, so the next request in the
    // input register always sees the state left by this one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call_state    <= csp_fsm_pkg::ST_IDLE;
            r_timer_running <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_advance) begin
                r_call_state    <= n_call_state;
                r_timer_running <= n_timer_running;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_verdict        <= c_verdict;
            r_call_state_out <= n_call_state;
            r_start_timer    <= c_start;
            r_stop_timer     <= c_stop;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_call_state_out = r_call_state_out;
    assign o_start_timer    = r_start_timer;
    assign o_stop_timer     = r_stop_timer;

    // An error verdict must leave the call state untouched.
    a_error_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (c_verdict == csp_fsm_pkg::V_INVALID ||
                      c_verdict == csp_fsm_pkg::V_TIMEOUT)
        |=> $stable(r_call_state))
        else $error("call state changed on an error verdict");

    // A pending result always shows the state the machine currently holds.
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_call_state_out == r_call_state))
        else $error("result call state differs from stored state");

    // A pending start request means the timer flag is set.
    a_start_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_timer |-> r_timer_running)
        else $error("timer start requested but flag clear");

    // A pending stop request means the timer flag was cleared.
    a_stop_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_timer |-> !r_timer_running)
        else $error("timer stop requested but flag still set");

endmodule
